// ===== design/lpf_pkg.sv =====
// shared constants, types and tables for the landmark polar feature block
// no dependencies; imported by every other design file
package lpf_pkg;

  localparam int NUM_POINTS   = 68;
  localparam int COORD_BITS   = 13;
  localparam int IDX_BITS     = 7;
  localparam int SLOT_BITS    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int TOT_BITS     = COORD_BITS + SLOT_BITS;
  localparam int OFF_BITS     = COORD_BITS + 1;
  localparam int RAD_BITS     = COORD_BITS + 5;
  localparam int ANG_BITS     = 17;
  localparam int ANGM_BITS    = 15;
  localparam int DEG90        = 23040;
  localparam int CORDIC_STEPS = 23;
  localparam int STEP_BITS    = 5;
  localparam int CX_BITS      = COORD_BITS + 21;
  localparam int CZ_BITS      = 25;
  localparam int SQ_BITS      = 2 * COORD_BITS + 10;
  localparam int CFG_ADDR_BITS = 8;

  // centroid divide by reciprocal multiply
  localparam int DIV_SH   = TOT_BITS + 7;
  localparam int DIV_MW   = DIV_SH - SLOT_BITS + 2;
  localparam int DIV_PW   = TOT_BITS + DIV_MW;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'(((64'd1 << DIV_SH) + 64'(NUM_POINTS) - 64'd1) / 64'(NUM_POINTS));

  localparam logic [CFG_ADDR_BITS-1:0] REG_NOSE_TOP    = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_NOSE_BOTTOM = CFG_ADDR_BITS'(1);
  localparam logic [IDX_BITS-1:0]      NOSE_TOP_RST    = IDX_BITS'(26);
  localparam logic [IDX_BITS-1:0]      NOSE_BOTTOM_RST = IDX_BITS'(29);

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // atan(2^-i) in 2^-16 degree
  localparam logic signed [CZ_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
    25'sd117265, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667,
    25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29,
    25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1
  };

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
  } cordic_req_t;

  function automatic logic [SLOT_BITS-1:0] clamp_slot(input logic [IDX_BITS-1:0] i);
    if (int'(i) < NUM_POINTS) return SLOT_BITS'(i);
    else return SLOT_BITS'(NUM_POINTS - 1);
  endfunction

endpackage

// ===== design/lpf_in_if.sv =====
// input channel: store or query transaction
// depends on lpf_pkg
interface lpf_in_if;
  import lpf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IDX_BITS-1:0]   point_index;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  modport source (output valid, op, point_index, coord_x, coord_y, input ready);
  modport sink   (input valid, op, point_index, coord_x, coord_y, output ready);
endinterface

// ===== design/lpf_out_if.sv =====
// result channel: polar features of one point
// depends on lpf_pkg
interface lpf_out_if;
  import lpf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OFF_BITS-1:0] offset_x;
  logic signed [OFF_BITS-1:0] offset_y;
  logic [RAD_BITS-1:0]        radius;
  logic signed [ANG_BITS-1:0] rel_angle;
  logic                       angle_undefined;
  logic [COORD_BITS-1:0]      center_x;
  logic [COORD_BITS-1:0]      center_y;
  modport source (output valid, offset_x, offset_y, radius, rel_angle, angle_undefined,
                  center_x, center_y, input ready);
  modport sink   (input valid, offset_x, offset_y, radius, rel_angle, angle_undefined,
                  center_x, center_y, output ready);
endinterface

// ===== design/lpf_cfg_if.sv =====
// configuration write channel
// depends on lpf_pkg
interface lpf_cfg_if;
  import lpf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [IDX_BITS-1:0]      wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== design/lpf_store.sv =====
// landmark point memory, one write and one registered read per cycle
// depends on lpf_pkg; entries never written read as zero through valid bits
module lpf_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [lpf_pkg::SLOT_BITS-1:0]  rd_addr,
  output logic [lpf_pkg::COORD_BITS-1:0] rd_x,
  output logic [lpf_pkg::COORD_BITS-1:0] rd_y,
  input  logic                           wr_en,
  input  logic [lpf_pkg::SLOT_BITS-1:0]  wr_addr,
  input  logic [lpf_pkg::COORD_BITS-1:0] wr_x,
  input  logic [lpf_pkg::COORD_BITS-1:0] wr_y
);
  import lpf_pkg::*;

  logic [2*COORD_BITS-1:0] mem [NUM_POINTS];
  logic [NUM_POINTS-1:0]   vld_r;
  logic [2*COORD_BITS-1:0] rd_data_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_x = rd_vld_r ? rd_data_r[2*COORD_BITS-1:COORD_BITS] : '0;
  assign rd_y = rd_vld_r ? rd_data_r[COORD_BITS-1:0] : '0;

endmodule

// ===== design/lpf_cordic.sv =====
// iterative vectoring cordic: atan(b/a) in 1/256 degree, one step per cycle
// depends on lpf_pkg
module lpf_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpf_pkg::cordic_req_t          req,
  output logic                          busy,
  output logic [lpf_pkg::ANGM_BITS-1:0] result
);
  import lpf_pkg::*;

  logic signed [CX_BITS-1:0] x_r, y_r, x_nxt, y_nxt, xs, ym, yms;
  logic signed [CZ_BITS-1:0] z_r, z_nxt;
  logic [CZ_BITS-1:0]        zp, zr;
  logic [STEP_BITS-1:0]      i_r;
  logic                      busy_r;
  logic [ANGM_BITS-1:0]      res_r, fin;

  always_comb begin
    xs    = x_r >>> i_r;
    ym    = y_r[CX_BITS-1] ? -y_r : y_r;
    yms   = ym >>> i_r;
    x_nxt = x_r + yms;
    if (!y_r[CX_BITS-1]) begin
      y_nxt = y_r - xs;
      z_nxt = z_r + ATAN_TAB[i_r];
    end else begin
      y_nxt = y_r + xs;
      z_nxt = z_r - ATAN_TAB[i_r];
    end
    // clamp at zero, round to 1/256 degree, clamp at 90 degrees
    zp = z_nxt + CZ_BITS'(128);
    zr = zp >> 8;
    if (z_nxt[CZ_BITS-1]) fin = '0;
    else if (zr > CZ_BITS'(DEG90)) fin = ANGM_BITS'(DEG90);
    else fin = zr[ANGM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      res_r  <= '0;
    end else if (req.start) begin
      if (req.b == '0) begin
        busy_r <= 1'b0;
        res_r  <= '0;
      end else begin
        busy_r <= 1'b1;
      end
    end else if (busy_r && i_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
      busy_r <= 1'b0;
      res_r  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= CX_BITS'({req.a, 16'd0});
      y_r <= CX_BITS'({req.b, 16'd0});
      z_r <= '0;
      i_r <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + STEP_BITS'(1);
    end
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

// ===== design/lpf_sqrt.sv =====
// bit-serial square root with round to nearest, one result bit per cycle
// depends on lpf_pkg
module lpf_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lpf_pkg::SQ_BITS-1:0]  value,
  output logic                         busy,
  output logic [lpf_pkg::RAD_BITS-1:0] result
);
  import lpf_pkg::*;

  logic [SQ_BITS-1:0]  rem_r, root_r, bit_r, rem_nxt, root_nxt, trial;
  logic                busy_r;
  logic [RAD_BITS-1:0] res_r;

  always_comb begin
    trial = root_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      rem_nxt  = rem_r;
      root_nxt = root_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      res_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      res_r  <= RAD_BITS'(root_nxt) + RAD_BITS'(rem_nxt > root_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= value;
      root_r <= '0;
      bit_r  <= SQ_BITS'(1) << (SQ_BITS - 2);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_r >> 2;
    end
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

// ===== design/landmark_polar_features.sv =====
// A store transaction writes one landmark and updates the coordinate sums; a store with
// an index out of range is dropped. A query runs three memory reads, the centroid
// multiply, the two squares and then two 23-step runs of the shared CORDIC unit (nose
// angle, then point angle); the rounded radius comes from an 18-step square root unit
// that runs alongside. One transaction is in work at a time; a finished result waits in
// the output register while the next transaction is accepted.
// Depends on lpf_pkg, the channel interfaces, lpf_store, lpf_cordic and lpf_sqrt.
module landmark_polar_features (
  input logic clk,
  input logic rst_n,
  lpf_in_if.sink    in_ch,
  lpf_out_if.source out_ch,
  lpf_cfg_if.sink   cfg_ch
);
  import lpf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ST    = 10'b0000000010,
    S_Q_T   = 10'b0000000100,
    S_Q_B   = 10'b0000001000,
    S_Q_S   = 10'b0000010000,
    S_Q_SQ  = 10'b0000100000,
    S_Q_SQ2 = 10'b0001000000,
    S_Q_NOS = 10'b0010000000,
    S_Q_ANG = 10'b0100000000,
    S_Q_OUT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_BITS-1:0]   nose_top_r, nose_bot_r;
  logic [TOT_BITS-1:0]   x_total_r, y_total_r;
  logic [IDX_BITS-1:0]   idx_r;
  logic [COORD_BITS-1:0] cx_in_r, cy_in_r;
  logic [DIV_PW-1:0]     prod_x_r, prod_y_r;
  logic [COORD_BITS-1:0] cx_r, cy_r, top_x_r, top_y_r;
  logic signed [OFF_BITS-1:0] ndx_r, ndy_r, ox_r, oy_r;
  logic signed [OFF_BITS-1:0] ox_c, oy_c;
  logic [2*COORD_BITS-1:0] sqx_r;
  logic signed [ANG_BITS-1:0] nose_r, nose_c, ang_c;
  logic [COORD_BITS-1:0] ax_ndx, ay_ndy, ax_ox, ay_oy;

  logic                  rd_en, wr_en;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic [COORD_BITS-1:0] rd_x, rd_y;

  cordic_req_t           creq;
  logic                  cbusy, sq_start, sbusy;
  logic [ANGM_BITS-1:0]  cres;
  logic [RAD_BITS-1:0]   sres;
  logic [SQ_BITS-1:0]    sq_val;

  logic in_acc, out_free, load;
  logic n_neg, p_neg;
  logic signed [ANG_BITS-1:0] cres_s;

  lpf_store u_store (
    .clk, .rst_n, .rd_en, .rd_addr, .rd_x, .rd_y,
    .wr_en, .wr_addr(SLOT_BITS'(idx_r)), .wr_x(cx_in_r), .wr_y(cy_in_r)
  );

  lpf_cordic u_cordic (.clk, .rst_n, .req(creq), .busy(cbusy), .result(cres));

  lpf_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .value(sq_val), .busy(sbusy), .result(sres)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_ch.valid || out_ch.ready;

  always_comb begin
    ax_ndx = ndx_r[OFF_BITS-1] ? COORD_BITS'(-ndx_r) : COORD_BITS'(ndx_r);
    ay_ndy = ndy_r[OFF_BITS-1] ? COORD_BITS'(-ndy_r) : COORD_BITS'(ndy_r);
    ax_ox  = ox_r[OFF_BITS-1] ? COORD_BITS'(-ox_r) : COORD_BITS'(ox_r);
    ay_oy  = oy_r[OFF_BITS-1] ? COORD_BITS'(-oy_r) : COORD_BITS'(oy_r);
    ox_c   = signed'(OFF_BITS'(rd_x)) - signed'(OFF_BITS'(cx_r));
    oy_c   = signed'(OFF_BITS'(rd_y)) - signed'(OFF_BITS'(cy_r));
    sq_val = SQ_BITS'({(SQ_BITS - 2*COORD_BITS - 1)'(1'b0) ,
                       ((2*COORD_BITS+1)'(sqx_r) + (2*COORD_BITS+1)'(ay_oy * ay_oy))})
             << 8;
    cres_s = signed'(ANG_BITS'(cres));

    // nose reference: atan of top minus bottom, shifted by 90 degrees toward zero
    n_neg = (ndy_r != '0) && (ndx_r[OFF_BITS-1] != ndy_r[OFF_BITS-1]);
    if (ndx_r == '0) nose_c = -ANG_BITS'(DEG90);
    else if (n_neg) nose_c = ANG_BITS'(DEG90) - cres_s;
    else nose_c = cres_s - ANG_BITS'(DEG90);

    p_neg = (oy_r != '0) && (ox_r[OFF_BITS-1] != oy_r[OFF_BITS-1]);
    if (ox_r == '0 && oy_r == '0) ang_c = '0;
    else if (ox_r == '0) ang_c = (oy_r[OFF_BITS-1] ? -ANG_BITS'(DEG90) : ANG_BITS'(DEG90))
                                 - nose_r;
    else ang_c = (p_neg ? -cres_s : cres_s) - nose_r;
  end

  always_comb begin
    state_nxt  = state_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    creq       = '{start: 1'b0, a: '0, b: '0};
    sq_start   = 1'b0;
    load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_STORE) begin
            if (int'(in_ch.point_index) < NUM_POINTS) begin
              rd_en     = 1'b1;
              rd_addr   = SLOT_BITS'(in_ch.point_index);
              state_nxt = S_ST;
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = clamp_slot(nose_top_r);
            state_nxt = S_Q_T;
          end
        end
      end
      S_ST: begin
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_Q_T: begin
        rd_en     = 1'b1;
        rd_addr   = clamp_slot(nose_bot_r);
        state_nxt = S_Q_B;
      end
      S_Q_B: begin
        rd_en     = 1'b1;
        rd_addr   = clamp_slot(idx_r);
        state_nxt = S_Q_S;
      end
      S_Q_S: begin
        creq      = '{start: 1'b1, a: ax_ndx, b: ay_ndy};
        state_nxt = S_Q_SQ;
      end
      S_Q_SQ: begin
        state_nxt = S_Q_SQ2;
      end
      S_Q_SQ2: begin
        sq_start  = 1'b1;
        state_nxt = S_Q_NOS;
      end
      S_Q_NOS: begin
        if (!cbusy) begin
          creq      = '{start: 1'b1, a: ax_ox, b: ay_oy};
          state_nxt = S_Q_ANG;
        end
      end
      S_Q_ANG: begin
        if (!cbusy && !sbusy) state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      nose_top_r <= NOSE_TOP_RST;
      nose_bot_r <= NOSE_BOTTOM_RST;
      x_total_r  <= '0;
      y_total_r  <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_NOSE_TOP:    nose_top_r <= cfg_ch.wdata;
          REG_NOSE_BOTTOM: nose_bot_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (wr_en) begin
        x_total_r <= x_total_r - TOT_BITS'(rd_x) + TOT_BITS'(cx_in_r);
        y_total_r <= y_total_r - TOT_BITS'(rd_y) + TOT_BITS'(cy_in_r);
      end
      if (load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= in_ch.point_index;
      cx_in_r <= in_ch.coord_x;
      cy_in_r <= in_ch.coord_y;
    end
    case (state_r)
      S_Q_T: begin
        top_x_r  <= rd_x;
        top_y_r  <= rd_y;
        prod_x_r <= DIV_PW'(x_total_r) * DIV_PW'(DIV_M);
        prod_y_r <= DIV_PW'(y_total_r) * DIV_PW'(DIV_M);
      end
      S_Q_B: begin
        ndx_r <= signed'(OFF_BITS'(top_x_r)) - signed'(OFF_BITS'(rd_x));
        ndy_r <= signed'(OFF_BITS'(top_y_r)) - signed'(OFF_BITS'(rd_y));
        cx_r  <= COORD_BITS'(prod_x_r >> DIV_SH);
        cy_r  <= COORD_BITS'(prod_y_r >> DIV_SH);
      end
      S_Q_S: begin
        ox_r <= ox_c;
        oy_r <= oy_c;
      end
      S_Q_SQ: sqx_r <= ax_ox * ax_ox;
      S_Q_NOS: if (!cbusy) nose_r <= nose_c;
      default: ;
    endcase
    if (load) begin
      out_ch.offset_x        <= ox_r;
      out_ch.offset_y        <= oy_r;
      out_ch.radius          <= sres;
      out_ch.rel_angle       <= ang_c;
      out_ch.angle_undefined <= (ox_r == '0) && (oy_r == '0);
      out_ch.center_x        <= cx_r;
      out_ch.center_y        <= cy_r;
    end
  end

endmodule
